FILE: design/assert_macros.svh
// Assertion macros for the checker of the LED driver chain.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SLD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sld: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SLD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sld: next-cycle check failed");

`endif

FILE: design/sld_pkg.sv
// Package of the serial LED driver chain: sizes, register addresses, item layouts
// and the Code-B font. Used by the top level and by the checker.
package sld_pkg;

    localparam int DEVICES   = 8;
    localparam int CAP       = (DEVICES < 8) ? DEVICES : 8;
    localparam int DEV_W     = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int MEM_DEPTH = DEVICES * 8;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [3:0] ADDR_NOOP       = 4'd0;
    localparam logic [3:0] ADDR_DIGIT_LO   = 4'd1;
    localparam logic [3:0] ADDR_DIGIT_HI   = 4'd8;
    localparam logic [3:0] ADDR_DECODE    = 4'd9;
    localparam logic [3:0] ADDR_INTENSITY = 4'd10;
    localparam logic [3:0] ADDR_SCAN_SPAN  = 4'd11;
    localparam logic [3:0] ADDR_SHUTDOWN   = 4'd12;
    localparam logic [3:0] ADDR_UNDEF_LO   = 4'd13;
    localparam logic [3:0] ADDR_UNDEF_HI   = 4'd14;
    localparam logic [3:0] ADDR_TEST       = 4'd15;

    localparam logic [7:0] CODE_B_FONT [16] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'h01, 8'h4F, 8'h37, 8'h0E, 8'h67, 8'h00};

    typedef struct packed {
        logic [2:0] view_digit;
        logic [2:0] view_device;
        logic       load_pin;
        logic       clock_pin;
        logic       data_pin;
    } in_item_t;

    localparam int IN_W        = $bits(in_item_t);
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;

    typedef struct packed {
        logic [3:0]  view_intensity;
        logic [7:0]  segments;
        logic        empty_latch;
        logic        burst_error;
        logic        reserved_addr;
        logic [15:0] raw_word;
        logic [7:0]  register_value;
        logic [3:0]  register_address;
        logic [2:0]  device_index;
    } res_item_t;

    localparam int RES_W       = $bits(res_item_t);
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

FILE: design/serial_led_driver_chain.sv
// Serial LED driver chain: pin-sample stream in, frame result stream out.
// Depends on sld_pkg for sizes, register addresses, item layouts and the font.
//
// Use:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes chain_length; write it
//   only while no item is in flight. cfg_ready is always high.
//   s_axis carries one pin sample per item (data, clock, load, viewed device
//   and digit). m_axis returns one result per item, or one result per chained
//   device when a rising load edge latches the chain, far device first;
//   tlast marks the final result of an item and tuser is frame_valid.
// Sequence:
//   An item without a latch goes from accept through a read of the digit memory
//   to its result. An item that latches n devices makes one register write pass
//   over the n devices, one read of the digit memory, then n results. A new item
//   is taken only once the last result of the previous one has been handed to the
//   output register.
// Reset: the chain, bit count, all device registers and the digit store read
//   as zero; chain_length returns to 1.
// Stall: while m_axis_tready is low a waiting result holds in the output register
//   and the result pass stops; one further item may be taken meanwhile.
module serial_led_driver_chain (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [3:0]                         cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // data_pin, clock_pin, load_pin, view_device[2:0], view_digit[2:0], zero fill
    input  logic [sld_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // device_index[2:0], register_address[3:0], register_value[7:0],
    // raw_word[15:0], reserved_addr, burst_error, empty_latch,
    // segments[7:0], view_intensity[3:0], zero fill
    output logic [sld_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // frame_valid
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);
    import sld_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WRITE, ST_READ, ST_EMIT} state_t;

    state_t            state_reg, state_next;
    logic [3:0]        chain_reg;
    logic              prev_clk_reg;
    logic              prev_load_reg;
    logic [15:0]       bit_count_reg;
    logic [15:0]       shift_reg     [DEVICES];
    logic [7:0]        decode_reg    [DEVICES];
    logic [3:0]        intensity_reg [DEVICES];
    logic [2:0]        scan_reg      [DEVICES];
    logic              run_reg       [DEVICES];
    logic              test_reg      [DEVICES];
    logic [MEM_DEPTH-1:0] dig_valid_reg;
    logic [7:0]        digit_mem     [MEM_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              rd_valid_reg;
    logic [2:0]        idx_reg;
    logic              latch_reg;
    logic              empty_reg;
    logic              bad_reg;
    logic [2:0]        vdev_reg;
    logic [2:0]        vdig_reg;
    logic              out_valid_reg;
    res_item_t         out_res_reg;
    logic              out_frame_reg;
    logic              out_last_reg;

    in_item_t          in_item;
    logic              in_acc;
    logic              shift_cond;
    logic              load_rise;
    logic [15:0]       cnt_after;
    logic              latch_now;
    logic [3:0]        n_eff;
    logic [2:0]        top_idx;
    logic [DEV_W-1:0]  wdev;
    logic [15:0]       wraw;
    logic [3:0]        waddr;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [MEM_AW-1:0] mem_raddr;
    logic              view_in;
    logic [DEV_W-1:0]  vdev;
    logic [7:0]        digit_val;
    logic [7:0]        seg;
    logic [3:0]        inten;
    logic              out_free;
    logic [15:0]       eraw;
    res_item_t         res_next;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_item       = in_item_t'(s_axis_tdata[IN_W-1:0]);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (chain_reg == 4'd0)
            n_eff = 4'd1;
        else if (32'(chain_reg) > CAP)
            n_eff = 4'(CAP);
        else
            n_eff = chain_reg;
        top_idx = 3'(n_eff - 4'd1);
    end

    assign shift_cond = in_item.clock_pin && !prev_clk_reg && !prev_load_reg;
    assign load_rise  = in_item.load_pin && !prev_load_reg;
    assign cnt_after  = (shift_cond && bit_count_reg != 16'hFFFF) ?
                        bit_count_reg + 16'd1 : bit_count_reg;
    assign latch_now  = load_rise && (cnt_after != 16'd0);

    assign wdev      = DEV_W'(idx_reg);
    assign wraw      = shift_reg[wdev];
    assign waddr     = wraw[11:8];
    assign mem_we    = (state_reg == ST_WRITE) && (waddr >= ADDR_DIGIT_LO)
                       && (waddr <= ADDR_DIGIT_HI);
    assign mem_waddr = MEM_AW'({idx_reg, 3'(waddr - ADDR_DIGIT_LO)});
    assign mem_raddr = MEM_AW'({vdev_reg, vdig_reg});

    assign view_in   = (32'(vdev_reg) < DEVICES);
    assign vdev      = DEV_W'(vdev_reg);
    assign digit_val = rd_valid_reg ? rd_data_reg : 8'h00;

    always_comb
    begin
        if (!view_in)
            seg = 8'h00;
        else if (test_reg[vdev])
            seg = 8'hFF;
        else if (!run_reg[vdev])
            seg = 8'h00;
        else if (vdig_reg > scan_reg[vdev])
            seg = 8'h00;
        else if (decode_reg[vdev][vdig_reg])
            seg = CODE_B_FONT[digit_val[3:0]] | (digit_val & 8'h80);
        else
            seg = digit_val;
        inten = view_in ? intensity_reg[vdev] : 4'd0;
    end

    assign out_free = !out_valid_reg || m_axis_tready;
    assign eraw     = shift_reg[DEV_W'(idx_reg)];

    always_comb
    begin
        res_next                = '0;
        res_next.segments       = seg;
        res_next.view_intensity = inten;
        if (latch_reg)
        begin
            res_next.device_index     = idx_reg;
            res_next.register_address = eraw[11:8];
            res_next.register_value   = eraw[7:0];
            res_next.raw_word         = eraw;
            res_next.reserved_addr    = (eraw[11:8] == ADDR_UNDEF_LO)
                                        || (eraw[11:8] == ADDR_UNDEF_HI);
            res_next.burst_error      = bad_reg;
        end
        else
        begin
            res_next.empty_latch = empty_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = latch_now ? ST_WRITE : ST_READ;
            end
            ST_WRITE:
            begin
                if (idx_reg == 3'd0)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free && (!latch_reg || idx_reg == 3'd0))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[mem_waddr] <= wraw[7:0];
        if (state_reg == ST_READ)
        begin
            rd_data_reg  <= digit_mem[mem_raddr];
            rd_valid_reg <= dig_valid_reg[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg     <= 4'd1;
            prev_clk_reg  <= 1'b0;
            prev_load_reg <= 1'b0;
            bit_count_reg <= '0;
            dig_valid_reg <= '0;
            idx_reg       <= '0;
            latch_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            vdev_reg      <= '0;
            vdig_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
            out_frame_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < DEVICES; i++)
            begin
                shift_reg[i]     <= '0;
                decode_reg[i]    <= '0;
                intensity_reg[i] <= '0;
                scan_reg[i]      <= '0;
                run_reg[i]       <= 1'b0;
                test_reg[i]      <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                chain_reg <= cfg_data;
            if (out_valid_reg && m_axis_tready && (state_reg != ST_EMIT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (shift_cond)
                        begin
                            shift_reg[0] <= {shift_reg[0][14:0], in_item.data_pin};
                            for (int i = 1; i < DEVICES; i++)
                            begin
                                if (i < 32'(n_eff))
                                    shift_reg[i] <= {shift_reg[i][14:0],
                                                     shift_reg[i-1][15]};
                            end
                        end
                        prev_clk_reg  <= in_item.clock_pin;
                        prev_load_reg <= in_item.load_pin;
                        bit_count_reg <= latch_now ? 16'd0 : cnt_after;
                        latch_reg     <= latch_now;
                        empty_reg     <= load_rise && (cnt_after == 16'd0);
                        bad_reg       <= (cnt_after != {8'd0, n_eff, 4'd0});
                        vdev_reg      <= in_item.view_device;
                        vdig_reg      <= in_item.view_digit;
                        idx_reg       <= top_idx;
                    end
                end
                ST_WRITE:
                begin
                    case (waddr)
                        ADDR_DECODE:     decode_reg[wdev]    <= wraw[7:0];
                        ADDR_INTENSITY:  intensity_reg[wdev] <= wraw[3:0];
                        ADDR_SCAN_SPAN:  scan_reg[wdev]      <= wraw[2:0];
                        ADDR_SHUTDOWN:   run_reg[wdev]       <= wraw[0];
                        ADDR_TEST:       test_reg[wdev]      <= wraw[0];
                        default:         ;
                    endcase
                    if (mem_we)
                        dig_valid_reg[mem_waddr] <= 1'b1;
                    if (idx_reg != 3'd0)
                        idx_reg <= idx_reg - 3'd1;
                end
                ST_READ:
                begin
                    idx_reg <= top_idx;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_res_reg   <= res_next;
                        out_frame_reg <= latch_reg;
                        out_last_reg  <= !latch_reg || (idx_reg == 3'd0);
                        if (latch_reg && idx_reg != 3'd0)
                            idx_reg <= idx_reg - 3'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_res_reg);
    assign m_axis_tuser  = out_frame_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: design/sld_checker.sv
// Port-level checker for the serial LED driver chain, bound to the top level.
// Depends on sld_pkg for channel widths and on assert_macros.svh.
`include "assert_macros.svh"

module sld_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sld_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                      m_axis_tuser,
    input logic                            m_axis_tlast
);
    import sld_pkg::*;

    logic near_frame;

    assign near_frame = m_axis_tvalid && m_axis_tuser[0] && (m_axis_tdata[2:0] == 3'd0);

    `SLD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SLD_ASSERT_NXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SLD_ASSERT_IMP(a_plain_result_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
    `SLD_ASSERT_IMP(a_empty_no_frame, m_axis_tvalid && m_axis_tdata[33], !m_axis_tuser[0])
    `SLD_ASSERT_IMP(a_near_device_last, near_frame, m_axis_tlast)

endmodule

bind serial_led_driver_chain sld_checker u_sld_checker (.*);

FILE: sim/serial_led_driver_chain_test.sv
// Self-checking bench for the serial LED driver chain: pin samples in, frame results out.
// Holds its own model of the chain, driver and monitor blocks; uses sld_pkg for types.
`timescale 1ns / 100ps

module serial_led_driver_chain_test;
    import sld_pkg::*;

    localparam int IN_DW  = IN_TDATA_W;
    localparam int OUT_DW = OUT_TDATA_W;
    localparam int PHASE_ITEMS = 12;
    localparam int TAIL_CYCLES = 24;

    localparam logic [7:0] CODE_B_GLYPH [16] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'h01, 8'h4F, 8'h37, 8'h0E, 8'h67, 8'h00};

    typedef struct packed {
        logic      frame_valid;
        logic      last;
        res_item_t body;
    } led_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [3:0]        cfg_data = 4'd0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [0:0]        m_axis_tuser;
    logic              m_axis_tlast;

    // model of the chain
    logic [3:0]  chain_len_cfg;
    logic        prev_clock_pin;
    logic        prev_load_pin;
    logic [15:0] shift_reg [DEVICES];
    logic [15:0] bits_clocked;
    logic [7:0]  digit_ram [DEVICES * 8];
    logic [7:0]  decode_bits [DEVICES];
    logic [3:0]  intensity [DEVICES];
    logic [2:0]  scan_span [DEVICES];
    logic        running [DEVICES];
    logic        testing [DEVICES];

    logic [IN_DW-1:0] pin_samples [$];
    led_result_t      awaited_results [$];

    int unsigned samples_queued = 0;
    int unsigned samples_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned frames_latched = 0;
    int unsigned malformed_frames = 0;
    int unsigned undefined_writes = 0;
    int unsigned empty_loads = 0;
    int unsigned settings_run = 1;
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned hold_left = 0;
    int unsigned hold_calm = 0;

    serial_led_driver_chain dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned active_count(logic [3:0] setting);
        if (setting == 4'd0)
            return 1;
        if (setting > CAP)
            return CAP;
        return setting;
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic logic [7:0] lit_segments(int unsigned dev, logic [2:0] g);
        logic [7:0] v;
        if (dev >= DEVICES)
            return 8'h00;
        if (testing[dev])
            return 8'hFF;
        if (!running[dev])
            return 8'h00;
        if (g > scan_span[dev])
            return 8'h00;
        v = digit_ram[dev * 8 + g];
        if (decode_bits[dev][g])
            return CODE_B_GLYPH[v[3:0]] | (v & 8'h80);
        return v;
    endfunction

    task automatic clear_chain_model();
        chain_len_cfg  = 4'd1;
        prev_clock_pin = 1'b0;
        prev_load_pin  = 1'b0;
        bits_clocked   = 16'd0;
        foreach (shift_reg[i])
            shift_reg[i] = 16'd0;
        foreach (digit_ram[i])
            digit_ram[i] = 8'd0;
        for (int i = 0; i < DEVICES; i++)
        begin
            decode_bits[i] = 8'd0;
            intensity[i]   = 4'd0;
            scan_span[i]   = 3'd0;
            running[i]     = 1'b0;
            testing[i]     = 1'b0;
        end
    endtask

    task automatic apply_write(int unsigned dev, logic [3:0] addr, logic [7:0] val);
        if (addr >= ADDR_DIGIT_LO && addr <= ADDR_DIGIT_HI)
            digit_ram[dev * 8 + int'(addr - ADDR_DIGIT_LO)] = val;
        else
            case (addr)
                ADDR_DECODE:     decode_bits[dev] = val;
                ADDR_INTENSITY:  intensity[dev] = val[3:0];
                ADDR_SCAN_SPAN:  scan_span[dev] = val[2:0];
                ADDR_SHUTDOWN:   running[dev] = val[0];
                ADDR_TEST:       testing[dev] = val[0];
                default:         ;
            endcase
    endtask

    // advance the model by one pin sample and queue the results it owes
    task automatic step_chain(in_item_t s);
        int unsigned n;
        int unsigned count;
        int          d;
        logic        carry;
        logic        spill;
        logic        malformed;
        logic        saw_empty;
        logic [15:0] raw;
        logic [7:0]  seg;
        logic [3:0]  inten;
        led_result_t batch [CAP];
        n = active_count(chain_len_cfg);
        count = 0;
        saw_empty = 1'b0;
        if (s.clock_pin && !prev_clock_pin && !prev_load_pin)
        begin
            carry = s.data_pin;
            for (d = 0; d < n; d++)
            begin
                spill = shift_reg[d][15];
                shift_reg[d] = {shift_reg[d][14:0], carry};
                carry = spill;
            end
            if (bits_clocked != 16'hFFFF)
                bits_clocked++;
        end
        prev_clock_pin = s.clock_pin;
        if (s.load_pin && !prev_load_pin)
        begin
            if (bits_clocked == 16'd0)
            begin
                saw_empty = 1'b1;
                empty_loads++;
            end
            else
            begin
                malformed = (bits_clocked != 16 * n);
                for (d = n - 1; d >= 0; d--)
                begin
                    raw = shift_reg[d];
                    apply_write(d, raw[11:8], raw[7:0]);
                    batch[count] = '0;
                    batch[count].frame_valid = 1'b1;
                    batch[count].body.device_index = 3'(d);
                    batch[count].body.register_address = raw[11:8];
                    batch[count].body.register_value = raw[7:0];
                    batch[count].body.raw_word = raw;
                    batch[count].body.reserved_addr =
                        (raw[11:8] == ADDR_UNDEF_LO || raw[11:8] == ADDR_UNDEF_HI);
                    batch[count].body.burst_error = malformed;
                    if (batch[count].body.reserved_addr)
                        undefined_writes++;
                    count++;
                end
                frames_latched += count;
                if (malformed)
                    malformed_frames++;
                bits_clocked = 16'd0;
            end
        end
        prev_load_pin = s.load_pin;
        if (count == 0)
        begin
            batch[0] = '0;
            batch[0].body.empty_latch = saw_empty;
            count = 1;
        end
        seg = lit_segments(s.view_device, s.view_digit);
        inten = (s.view_device < DEVICES) ? intensity[s.view_device] : 4'd0;
        for (d = 0; d < count; d++)
        begin
            batch[d].last = (d == count - 1);
            batch[d].body.segments = seg;
            batch[d].body.view_intensity = inten;
            awaited_results.push_back(batch[d]);
        end
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s wrong on result %0d: got 0x%0h, expected 0x%0h",
                     $time, what, results_seen, got, want);
    endtask

    task automatic check_result();
        res_item_t   got;
        led_result_t want;
        got = m_axis_tdata[RES_W-1:0];
        results_seen++;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("unexpected result", got, 0);
            return;
        end
        want = awaited_results.pop_front();
        if (m_axis_tuser[0] !== want.frame_valid)
            report_mismatch("frame_valid", m_axis_tuser[0], want.frame_valid);
        if (m_axis_tlast !== want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        if (got.device_index !== want.body.device_index)
            report_mismatch("device_index", got.device_index, want.body.device_index);
        if (got.register_address !== want.body.register_address)
            report_mismatch("register_address", got.register_address,
                            want.body.register_address);
        if (got.register_value !== want.body.register_value)
            report_mismatch("register_value", got.register_value, want.body.register_value);
        if (got.raw_word !== want.body.raw_word)
            report_mismatch("raw_word", got.raw_word, want.body.raw_word);
        if (got.reserved_addr !== want.body.reserved_addr)
            report_mismatch("reserved_addr", got.reserved_addr,
                            want.body.reserved_addr);
        if (got.burst_error !== want.body.burst_error)
            report_mismatch("burst_error", got.burst_error,
                            want.body.burst_error);
        if (got.empty_latch !== want.body.empty_latch)
            report_mismatch("empty_latch", got.empty_latch, want.body.empty_latch);
        if (got.segments !== want.body.segments)
            report_mismatch("segments", got.segments, want.body.segments);
        if (got.view_intensity !== want.body.view_intensity)
            report_mismatch("view_intensity", got.view_intensity, want.body.view_intensity);
    endtask

    // driver: present queued pin samples, idle at random between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
            send_calm     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                step_chain(in_item_t'(s_axis_tdata[IN_W-1:0]));
                samples_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0 || pin_samples.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pin_samples.pop_front();
                    if (send_calm > 0)
                    begin
                        send_calm <= send_calm - 1;
                        send_gap  <= 0;
                    end
                    else
                    begin
                        send_gap <= pick_idle();
                        if ($urandom_range(0, 39) == 0)
                            send_calm <= $urandom_range(20, 60);
                    end
                end
            end
        end
    end

    // monitor: check each accepted result, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_calm     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end
            else if (hold_calm > 0)
            begin
                m_axis_tready <= 1'b1;
                hold_calm     <= hold_calm - 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left     <= pick_idle();
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    hold_calm <= $urandom_range(20, 60);
            end
        end
    end

    task automatic queue_sample(logic d, logic c, logic l, logic [2:0] vdev, logic [2:0] vdig);
        in_item_t         s;
        logic [IN_DW-1:0] word;
        s.data_pin    = d;
        s.clock_pin   = c;
        s.load_pin    = l;
        s.view_device = vdev;
        s.view_digit  = vdig;
        word = '0;
        word[IN_W-1:0] = s;
        pin_samples.push_back(word);
        samples_queued++;
    endtask

    // mostly look at a device inside the chain
    task automatic queue_pins(logic d, logic c, logic l);
        logic [2:0] vdev;
        if ($urandom_range(0, 3) == 0)
            vdev = 3'($urandom_range(0, 7));
        else
            vdev = 3'($urandom_range(0, active_count(chain_len_cfg) - 1));
        queue_sample(d, c, l, vdev, 3'($urandom_range(0, 7)));
    endtask

    task automatic queue_bit(logic b);
        queue_pins(1'($urandom_range(0, 1)), 1'b0, 1'b0);
        queue_pins(b, 1'b1, 1'b0);
    endtask

    task automatic queue_latch();
        queue_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
        queue_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    endtask

    // far device's word goes out first
    task automatic queue_frame(logic [15:0] words [CAP], int unsigned n);
        int d;
        queue_pins(1'($urandom_range(0, 1)), 1'b0, 1'b0);
        for (d = n - 1; d >= 0; d--)
            for (int b = 15; b >= 0; b--)
                queue_bit(words[d][b]);
        queue_latch();
    endtask

    function automatic logic [15:0] random_word();
        logic [3:0] addr;
        logic [7:0] val;
        addr = 4'($urandom_range(0, 15));
        val  = 8'($urandom_range(0, 255));
        if (addr == ADDR_SHUTDOWN)
            val[0] = ($urandom_range(0, 3) != 0);
        if (addr == ADDR_TEST)
            val[0] = ($urandom_range(0, 4) == 0);
        return {4'($urandom_range(0, 15)), addr, val};
    endfunction

    task automatic run_random(int unsigned budget);
        int unsigned start;
        int unsigned n;
        int unsigned r;
        int unsigned k;
        logic [15:0] words [CAP];
        start = samples_queued;
        n = active_count(chain_len_cfg);
        while (samples_queued - start < budget)
        begin
            r = $urandom_range(0, 99);
            if (n == 1 && r < 45)
            begin
                foreach (words[i])
                    words[i] = random_word();
                queue_frame(words, n);
            end
            else if (r < 80)
            begin
                if (n > 1 || $urandom_range(0, 1) == 0)
                    k = $urandom_range(1, 12);
                else
                    k = ($urandom_range(0, 1) == 0) ? 16 * n + 1 : 16 * n - 1;
                queue_pins(1'($urandom_range(0, 1)), 1'b0, 1'b0);
                repeat (k)
                    queue_bit(1'($urandom_range(0, 1)));
                queue_latch();
            end
            else
                repeat ($urandom_range(1, 6))
                    queue_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
        end
    endtask

    // hold until every queued sample is taken and every result is back
    task automatic wait_drained();
        while (samples_accepted != samples_queued || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_chain_length(logic [3:0] value);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        chain_len_cfg = value;
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // switch both devices of a two-device chain on
    task automatic queue_register_tour();
        logic [15:0] words [CAP];
        foreach (words[i])
            words[i] = 16'd0;
        words[1] = {4'h5, ADDR_SHUTDOWN, 8'h01};
        words[0] = {4'hF, ADDR_SHUTDOWN, 8'h81};
        queue_frame(words, 2);
    endtask

    initial
    begin
        clear_chain_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // pin edge cases with a single device
        queue_sample(1'b0, 1'b0, 1'b0, 3'd7, 3'd7);
        queue_sample(1'b1, 1'b0, 1'b1, 3'd0, 3'd0);
        queue_sample(1'b0, 1'b1, 1'b1, 3'd7, 3'd0);
        queue_sample(1'b0, 1'b0, 1'b0, 3'd0, 3'd7);
        queue_sample(1'b1, 1'b1, 1'b1, 3'd0, 3'd3);
        queue_sample(1'b0, 1'b0, 1'b0, 3'd1, 3'd0);
        queue_sample(1'b1, 1'b1, 1'b0, 3'd0, 3'd0);
        queue_sample(1'b0, 1'b1, 1'b0, 3'd7, 3'd7);
        queue_sample(1'b1, 1'b0, 1'b0, 3'd0, 3'd1);
        queue_sample(1'b1, 1'b0, 1'b1, 3'd0, 3'd0);
        queue_sample(1'b0, 1'b1, 1'b0, 3'd0, 3'd0);
        wait_drained();
        run_random(PHASE_ITEMS);

        set_chain_length(4'd2);
        queue_register_tour();
        run_random(PHASE_ITEMS);
        set_chain_length(4'd15);
        run_random(PHASE_ITEMS);
        set_chain_length(4'd0);
        run_random(PHASE_ITEMS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d pin samples over %0d chain settings, %0d results checked.",
                 samples_accepted, settings_run, results_seen);
        $display("Latched %0d frames, %0d malformed bursts, %0d undefined writes, %0d empty loads.",
                 frames_latched, malformed_frames, undefined_writes, empty_loads);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
